// ----- rtl/wvlfs_pkg.sv -----
// Package for the value, label and frame stack unit.
// Holds the request and response word types, operation and status codes
// and the layout of one stack entry. No dependencies.
package wvlfs_pkg;

    // Operation codes carried in the kind field of a request word.
    localparam logic [2:0] K_PUSH_VAL  = 3'd0;
    localparam logic [2:0] K_PUSH_LBL  = 3'd1;
    localparam logic [2:0] K_PUSH_FRM  = 3'd2;
    localparam logic [2:0] K_POP_VAL   = 3'd3;
    localparam logic [2:0] K_POP_LBL   = 3'd4;
    localparam logic [2:0] K_POP_LBL_K = 3'd5;
    localparam logic [2:0] K_POP_FRM   = 3'd6;

    // Status codes of a response word.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_LABEL = 3'd1;
    localparam logic [2:0] ST_NOT_VAL  = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_TYPE     = 3'd4;
    localparam logic [2:0] ST_NO_FRAME = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // Entry kinds held in the low tag bits.
    localparam logic [1:0] EK_VALUE = 2'd0;
    localparam logic [1:0] EK_LABEL = 2'd1;
    localparam logic [1:0] EK_FRAME = 2'd2;

    typedef struct packed {
        logic [2:0]         kind;
        logic [1:0]         value_type;
        logic signed [63:0] value_data;
        logic [15:0]        label_tag;
        logic [2:0]         result_count;
        logic [7:0]         result_types;
        logic [15:0]        frame_tag;
    } req_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [1:0]         out_type;
        logic signed [63:0] out_data;
        logic [15:0]        out_label_tag;
        logic [15:0]        out_frame_tag;
        logic               has_label;
        logic               has_frame;
        logic [10:0]        depth;
    } rsp_word_t;

    // One stack entry: payload, value type and entry kind.
    typedef struct packed {
        logic [63:0] payload;
        logic [1:0]  vtype;
        logic [1:0]  ekind;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- rtl/wvlfs_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module wvlfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/wasm_value_label_frame_stack_unit.sv -----
// Top level of the value, label and frame stack unit.
// Depends on wvlfs_pkg and wvlfs_ram.

// One stack of tagged entries (typed values, labels, frames) lives in a single
// RAM with a registered read; a sequencer reads, checks and writes it at most
// one access a cycle and handles one request word at a time. A pop label reads
// the label and its kept results, copies them down and then rescans for the
// nearest frame and label, one entry at a time; a pop frame walks up to the
// first label, down over the kept values, writes them back and rescans in the
// same way, so unwinds take a time set by the number of entries that the RAM
// port must visit. A finished response waits in an output register while the
// next request word is taken. Reset needs no clearing pass: only entries
// below the top are read.
module wasm_value_label_frame_stack_unit #(
    parameter int STACK_DEPTH       = 1024,
    parameter int MAX_LABEL_RESULTS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  wvlfs_pkg::req_word_t  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output wvlfs_pkg::rsp_word_t  rsp
);

    import wvlfs_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(STACK_DEPTH + 1);
    localparam int KW = MAX_LABEL_RESULTS;
    localparam int IW = (KW > 1) ? $clog2(KW) : 1;
    localparam logic [2:0] MAXC = 3'(MAX_LABEL_RESULTS);

    typedef enum logic [3:0] {
        S_IDLE, S_PV_CHK, S_LB_HDR, S_LB_CHK, S_LB_WR, S_FR_HDR, S_FR_UP_RD,
        S_FR_UP_CHK, S_FR_DN_RD, S_FR_DN_CHK, S_FR_WR, S_SC_RD, S_SC_CHK, S_FIN
    } state_t;

    state_t          state_reg, state_next;
    logic [PW-1:0]   top_reg, top_next;
    logic [AW-1:0]   lbl_idx_reg, lbl_idx_next;
    logic [AW-1:0]   frm_idx_reg, frm_idx_next;
    logic            lbl_vld_reg, lbl_vld_next;
    logic            frm_vld_reg, frm_vld_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [7:0]      types_reg, types_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic [2:0]      n_reg, n_next;
    entry_t          buf_reg [KW];
    entry_t          buf_next [KW];
    logic [2:0]      st_reg, st_next;
    logic [1:0]      otype_reg, otype_next;
    logic [63:0]     odata_reg, odata_next;
    logic [15:0]     oltag_reg, oltag_next;
    logic [15:0]     oftag_reg, oftag_next;
    rsp_word_t       rsp_reg, rsp_next;
    logic            rsp_vld_reg, rsp_vld_next;

    logic            we;
    logic [AW-1:0]   waddr;
    entry_t          wdata;
    logic [AW-1:0]   raddr;
    entry_t          rdata;
    logic [ENTRY_W-1:0] rdata_bits;
    logic [PW-1:0]   avail;
    logic [2:0]      req_cnt;

    assign rdata     = entry_t'(rdata_bits);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_reg;
    assign req_cnt   = (req.result_count > MAXC) ? MAXC : req.result_count;
    assign avail     = top_reg - PW'(lbl_idx_reg) - PW'(1);

    wvlfs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_bits)
    );

    // Sequencer: decodes a request word, walks the RAM and builds the response.
    always_comb
    begin
        state_next   = state_reg;
        top_next     = top_reg;
        lbl_idx_next = lbl_idx_reg;
        frm_idx_next = frm_idx_reg;
        lbl_vld_next = lbl_vld_reg;
        frm_vld_next = frm_vld_reg;
        cnt_next     = cnt_reg;
        types_next   = types_reg;
        ptr_next     = ptr_reg;
        n_next       = n_reg;
        buf_next     = buf_reg;
        st_next      = st_reg;
        otype_next   = otype_reg;
        odata_next   = odata_reg;
        oltag_next   = oltag_reg;
        oftag_next   = oftag_reg;
        rsp_next     = rsp_reg;
        rsp_vld_next = rsp_vld_reg;
        we           = 1'b0;
        waddr        = top_reg[AW-1:0];
        wdata        = '0;
        raddr        = ptr_reg[AW-1:0];

        if (rsp_vld_reg && rsp_ready)
        begin
            rsp_vld_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    st_next    = ST_OK;
                    otype_next = '0;
                    odata_next = '0;
                    oltag_next = '0;
                    oftag_next = '0;
                    state_next = S_FIN;
                    unique case (req.kind)
                        K_PUSH_VAL, K_PUSH_LBL, K_PUSH_FRM:
                        begin
                            if (top_reg == PW'(STACK_DEPTH))
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                we       = 1'b1;
                                top_next = top_reg + PW'(1);
                                if (req.kind == K_PUSH_VAL)
                                begin
                                    wdata = '{payload: req.value_data,
                                              vtype: req.value_type, ekind: EK_VALUE};
                                end
                                else if (req.kind == K_PUSH_LBL)
                                begin
                                    wdata = '{payload: {37'd0, req.result_types, req_cnt,
                                                        req.label_tag},
                                              vtype: 2'd0, ekind: EK_LABEL};
                                    lbl_idx_next = top_reg[AW-1:0];
                                    lbl_vld_next = 1'b1;
                                end
                                else
                                begin
                                    wdata = '{payload: {48'd0, req.frame_tag},
                                              vtype: 2'd0, ekind: EK_FRAME};
                                    frm_idx_next = top_reg[AW-1:0];
                                    frm_vld_next = 1'b1;
                                    lbl_vld_next = 1'b0;
                                end
                            end
                        end
                        K_POP_VAL:
                        begin
                            if (top_reg == '0)
                            begin
                                st_next = ST_NOT_VAL;
                            end
                            else
                            begin
                                raddr      = AW'(top_reg - PW'(1));
                                state_next = S_PV_CHK;
                            end
                        end
                        K_POP_LBL, K_POP_LBL_K:
                        begin
                            if (!lbl_vld_reg)
                            begin
                                st_next = ST_NO_LABEL;
                            end
                            else
                            begin
                                raddr      = lbl_idx_reg;
                                cnt_next   = {2'd0, req.kind == K_POP_LBL_K};
                                state_next = S_LB_HDR;
                            end
                        end
                        K_POP_FRM:
                        begin
                            if (!frm_vld_reg)
                            begin
                                st_next = ST_NO_FRAME;
                            end
                            else
                            begin
                                raddr      = frm_idx_reg;
                                cnt_next   = req_cnt;
                                state_next = S_FR_HDR;
                            end
                        end
                        default:
                        begin
                            st_next = ST_OK;
                        end
                    endcase
                end
            end

            // Top entry of a pop value has arrived.
            S_PV_CHK:
            begin
                state_next = S_FIN;
                if (rdata.ekind != EK_VALUE)
                begin
                    st_next = ST_NOT_VAL;
                end
                else
                begin
                    top_next   = top_reg - PW'(1);
                    otype_next = rdata.vtype;
                    odata_next = rdata.payload;
                end
            end

            // Label header: arity, result types and handle.
            S_LB_HDR:
            begin
                if (cnt_reg[0])
                begin
                    cnt_next = rdata.payload[18:16];
                end
                else
                begin
                    cnt_next = '0;
                end
                types_next = rdata.payload[26:19];
                if (PW'(cnt_next) > avail)
                begin
                    st_next    = ST_MISSING;
                    state_next = S_FIN;
                end
                else
                begin
                    oltag_next = rdata.payload[15:0];
                    n_next     = '0;
                    if (cnt_next == '0)
                    begin
                        top_next   = PW'(lbl_idx_reg);
                        state_next = S_LB_WR;
                    end
                    else
                    begin
                        ptr_next   = top_reg - PW'(cnt_next);
                        raddr      = AW'(top_reg - PW'(cnt_next));
                        state_next = S_LB_CHK;
                    end
                end
            end

            // Check one kept result against its declared type.
            S_LB_CHK:
            begin
                if (rdata.vtype != types_reg[{n_reg[1:0], 1'b0} +: 2])
                begin
                    st_next    = ST_TYPE;
                    oltag_next = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    buf_next[n_reg[IW-1:0]] = rdata;
                    if (n_reg == cnt_reg - 3'd1)
                    begin
                        n_next     = '0;
                        top_next   = PW'(lbl_idx_reg);
                        state_next = S_LB_WR;
                    end
                    else
                    begin
                        n_next   = n_reg + 3'd1;
                        ptr_next = ptr_reg + PW'(1);
                        raddr    = AW'(ptr_reg + PW'(1));
                    end
                end
            end

            // Copy kept results down over the label.
            S_LB_WR:
            begin
                if (n_reg == cnt_reg)
                begin
                    ptr_next     = top_reg;
                    lbl_vld_next = 1'b0;
                    frm_vld_next = 1'b0;
                    state_next   = S_SC_RD;
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = buf_reg[n_reg[IW-1:0]];
                    n_next   = n_reg + 3'd1;
                    top_next = top_reg + PW'(1);
                end
            end

            // Frame header: take its handle, then look for the first label.
            S_FR_HDR:
            begin
                oftag_next = rdata.payload[15:0];
                ptr_next   = PW'(frm_idx_reg) + PW'(1);
                state_next = S_FR_UP_RD;
            end

            S_FR_UP_RD:
            begin
                if (ptr_reg >= top_reg)
                begin
                    ptr_next   = top_reg;
                    n_next     = '0;
                    state_next = S_FR_DN_RD;
                end
                else
                begin
                    state_next = S_FR_UP_CHK;
                end
            end

            S_FR_UP_CHK:
            begin
                if (rdata.ekind == EK_LABEL)
                begin
                    cnt_next   = rdata.payload[18:16];
                    ptr_next   = top_reg;
                    n_next     = '0;
                    state_next = S_FR_DN_RD;
                end
                else
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = S_FR_UP_RD;
                end
            end

            // Walk down from the top, gathering the values to keep.
            S_FR_DN_RD:
            begin
                if (ptr_reg <= PW'(frm_idx_reg) + PW'(1) || n_reg >= cnt_reg)
                begin
                    top_next   = PW'(frm_idx_reg);
                    state_next = S_FR_WR;
                end
                else
                begin
                    raddr      = AW'(ptr_reg - PW'(1));
                    ptr_next   = ptr_reg - PW'(1);
                    state_next = S_FR_DN_CHK;
                end
            end

            S_FR_DN_CHK:
            begin
                if (rdata.ekind == EK_VALUE)
                begin
                    buf_next[n_reg[IW-1:0]] = rdata;
                    n_next = n_reg + 3'd1;
                end
                state_next = S_FR_DN_RD;
            end

            // Push the kept values back, deepest first.
            S_FR_WR:
            begin
                if (n_reg == '0)
                begin
                    ptr_next     = top_reg;
                    lbl_vld_next = 1'b0;
                    frm_vld_next = 1'b0;
                    state_next   = S_SC_RD;
                end
                else
                begin
                    we       = 1'b1;
                    wdata    = buf_reg[IW'(n_reg - 3'd1)];
                    n_next   = n_reg - 3'd1;
                    top_next = top_reg + PW'(1);
                end
            end

            // Rescan downwards for the nearest frame and the label above it.
            S_SC_RD:
            begin
                if (ptr_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    raddr      = AW'(ptr_reg - PW'(1));
                    ptr_next   = ptr_reg - PW'(1);
                    state_next = S_SC_CHK;
                end
            end

            S_SC_CHK:
            begin
                state_next = S_SC_RD;
                if (rdata.ekind == EK_LABEL && !lbl_vld_reg)
                begin
                    lbl_vld_next = 1'b1;
                    lbl_idx_next = ptr_reg[AW-1:0];
                end
                else if (rdata.ekind == EK_FRAME)
                begin
                    frm_vld_next = 1'b1;
                    frm_idx_next = ptr_reg[AW-1:0];
                    state_next   = S_FIN;
                end
            end

            // Hand the response word to the output register once it is free.
            S_FIN:
            begin
                if (!rsp_vld_reg || rsp_ready)
                begin
                    rsp_next = '{status: st_reg, out_type: otype_reg,
                                 out_data: odata_reg, out_label_tag: oltag_reg,
                                 out_frame_tag: oftag_reg, has_label: lbl_vld_reg,
                                 has_frame: frm_vld_reg, depth: 11'(top_reg)};
                    rsp_vld_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            top_reg     <= '0;
            lbl_vld_reg <= 1'b0;
            frm_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            lbl_vld_reg <= lbl_vld_next;
            frm_vld_reg <= frm_vld_next;
            rsp_vld_reg <= rsp_vld_next;
            n_reg       <= n_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        lbl_idx_reg <= lbl_idx_next;
        frm_idx_reg <= frm_idx_next;
        cnt_reg     <= cnt_next;
        types_reg   <= types_next;
        ptr_reg     <= ptr_next;
        buf_reg     <= buf_next;
        st_reg      <= st_next;
        otype_reg   <= otype_next;
        odata_reg   <= odata_next;
        oltag_reg   <= oltag_next;
        oftag_reg   <= oftag_next;
        rsp_reg     <= rsp_next;
    end

    // The stack never holds more entries than it has room for.
    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= PW'(STACK_DEPTH))
        else $error("stack top beyond depth");

    // In the idle state, a current label always lies above the current frame.
    a_label_above_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && lbl_vld_reg && frm_vld_reg) |->
        (lbl_idx_reg > frm_idx_reg))
        else $error("label below frame");

    // A response appears only from the finishing step.
    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_vld_reg) |-> $past(state_reg == S_FIN))
        else $error("response outside finishing step");

    // RAM writes never land above the current top.
    a_write_at_top: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (PW'(waddr) == top_reg && top_reg < PW'(STACK_DEPTH)))
        else $error("write away from top");

endmodule
